[rtl/core/slt_pkg.sv]
// Shared types and constants for the shell line tokenizer.
// Record kinds, lexer modes, queue command layout and character helpers.
// No dependencies.
package slt_pkg;

	// Records one input byte can cause, and default queue depth
	localparam int MAX_RECS        = 5;
	localparam int NREC_W          = $clog2(MAX_RECS + 1);
	localparam int QUEUE_DEPTH_DEF = 4;

	typedef enum logic [2:0] {
		K_CHAR = 3'd0,
		K_WEND = 3'd1,
		K_OUT  = 3'd2,
		K_APP  = 3'd3,
		K_DUP  = 3'd4,
		K_IN   = 3'd5,
		K_END  = 3'd6,
		K_ERR  = 3'd7
	} kind_t;

	typedef enum logic [3:0] {
		M_START = 4'd0,
		M_DIGIT = 4'd1,
		M_GT    = 4'd2,
		M_DUP   = 4'd3,
		M_LBR   = 4'd4,
		M_WORD  = 4'd5,
		M_BSL   = 4'd6,
		M_ESC   = 4'd7,
		M_DONE  = 4'd8
	} mode_t;

	typedef enum logic [1:0] {
		Q_NONE   = 2'd0,
		Q_SINGLE = 2'd1,
		Q_DOUBLE = 2'd2
	} quote_t;

	// Error codes carried in the record data byte
	localparam logic [7:0] ERR_NO_FD    = 8'd1;
	localparam logic [7:0] ERR_UNCLOSED = 8'd2;

	// Characters
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SP    = 8'h20;
	localparam logic [7:0] CH_DQ    = 8'h22;
	localparam logic [7:0] CH_AMP   = 8'h26;
	localparam logic [7:0] CH_SQ    = 8'h27;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_LT    = 8'h3C;
	localparam logic [7:0] CH_GT    = 8'h3E;
	localparam logic [7:0] CH_LBR   = 8'h5B;
	localparam logic [7:0] CH_BSL   = 8'h5C;
	localparam logic [7:0] CH_RBR   = 8'h5D;
	localparam logic [7:0] CH_BAR   = 8'h7C;
	localparam logic [7:0] CH_T     = 8'h74;
	localparam logic [7:0] CH_E     = 8'h65;
	localparam logic [7:0] CH_S     = 8'h73;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] data;   // character, or error code for K_ERR
	} rec_t;

	// One queued transaction: the records one byte produced
	typedef struct packed {
		rec_t [MAX_RECS-1:0] recs;
		logic [NREC_W-1:0]   nrec;
		logic [3:0]          fd_left;
		logic [15:0]         fd_right;
	} cmd_t;

	function automatic logic is_space(input logic [7:0] c);
		return (c == CH_SP) || (c >= CH_TAB && c <= CH_CR);
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= CH_0) && (c <= CH_9);
	endfunction

	function automatic logic is_special(input logic [7:0] c);
		return (c == CH_GT) || (c == CH_LT) || (c == CH_AMP) || (c == CH_BAR);
	endfunction

endpackage

[rtl/core/slt_front.sv]
// Lexer front end: accepts one byte per transaction and turns it into a
// queue command listing the records it causes. Holds lexer state and config.
// Depends on slt_pkg.
module slt_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic          cfg_index,
	input  logic          cfg_wdata,
	input  logic          accept,
	input  logic [7:0]    ch,
	input  logic          start_line,
	output logic          push,
	output slt_pkg::cmd_t cmd
);
	import slt_pkg::*;

	typedef struct packed {
		mode_t      m;
		quote_t     q;
		logic       emit;
		kind_t      kind;
		logic [7:0] data;
		logic       again;
	} wstep_t;

	logic       test_conv_q;
	logic       keep_q;
	mode_t      mode_q;
	quote_t     quote_q;
	logic [7:0] held_q;
	logic [3:0] lfd_q;
	logic [15:0] acc_q;
	logic       seen_q;

	mode_t      m;
	quote_t     q;
	logic [7:0] held;
	logic [3:0] lfd;
	logic [15:0] acc;
	logic       seen;

	function automatic cmd_t add_rec(input cmd_t c, input kind_t k, input logic [7:0] d);
		cmd_t r;
		r = c;
		r.recs[c.nrec] = '{kind: k, data: d};
		r.nrec = c.nrec + NREC_W'(1);
		return r;
	endfunction

	// One step in word mode
	function automatic wstep_t word_step(input logic [7:0] c, input quote_t qs, input logic keep);
		wstep_t w;
		w = '{m: M_WORD, q: qs, emit: 1'b0, kind: K_CHAR, data: c, again: 1'b0};
		if (c == CH_NUL) begin
			w.emit = 1'b1;
			if (qs != Q_NONE) begin
				w.kind = K_ERR;
				w.data = ERR_UNCLOSED;
				w.q = Q_NONE;
			end else begin
				w.kind = K_WEND;
				w.data = CH_NUL;
			end
			w.m = M_START;
			w.again = 1'b1;
		end else if (is_space(c) || is_special(c)) begin
			if (qs != Q_NONE) begin
				w.emit = 1'b1;
			end else begin
				w.emit = 1'b1;
				w.kind = K_WEND;
				w.data = CH_NUL;
				w.m = M_START;
				w.again = 1'b1;
			end
		end else if (c == CH_SQ) begin
			if (qs == Q_DOUBLE) begin
				w.emit = 1'b1;
			end else begin
				w.q = (qs == Q_SINGLE) ? Q_NONE : Q_SINGLE;
				w.emit = keep;
			end
		end else if (c == CH_DQ) begin
			if (qs == Q_SINGLE) begin
				w.emit = 1'b1;
			end else begin
				w.q = (qs == Q_DOUBLE) ? Q_NONE : Q_DOUBLE;
				w.emit = keep;
			end
		end else if (c == CH_BSL) begin
			if (qs == Q_SINGLE || keep)
				w.emit = 1'b1;
			else
				w.m = M_BSL;
		end else begin
			w.emit = 1'b1;
		end
		return w;
	endfunction

	// Config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			test_conv_q <= 1'b0;
			keep_q <= 1'b0;
		end else if (cfg_we) begin
			if (cfg_index == 1'b0)
				test_conv_q <= cfg_wdata;
			else
				keep_q <= cfg_wdata;
		end
	end

	// Lexer: resolve up to four chained steps for one byte
	always_comb begin
		logic       pend;
		logic [19:0] v;
		wstep_t     w;
		cmd_t       c;

		if (start_line) begin
			m = M_START;
			q = Q_NONE;
			held = '0;
			lfd = 4'd1;
			acc = '0;
			seen = 1'b0;
		end else begin
			m = mode_q;
			q = quote_q;
			held = held_q;
			lfd = lfd_q;
			acc = acc_q;
			seen = seen_q;
		end
		pend = 1'b1;
		c = '0;
		v = '0;
		w = '0;

		// Modes that look at one byte before a word or token start
		unique case (m)
			M_DIGIT: begin
				if (ch == CH_GT) begin
					lfd = 4'(held - CH_0);
					m = M_GT;
					pend = 1'b0;
				end else begin
					c = add_rec(c, K_CHAR, held);
					m = M_WORD;
					q = Q_NONE;
				end
			end
			M_GT: begin
				if (ch == CH_GT) begin
					c = add_rec(c, K_APP, CH_NUL);
					c.fd_left = lfd;
					m = M_START;
					pend = 1'b0;
				end else if (ch == CH_AMP) begin
					acc = '0;
					seen = 1'b0;
					m = M_DUP;
					pend = 1'b0;
				end else begin
					c = add_rec(c, K_OUT, CH_NUL);
					c.fd_left = lfd;
					m = M_START;
				end
			end
			M_DUP: begin
				if (is_digit(ch)) begin
					v = {acc, 3'b000} + {2'b00, acc, 1'b0} + {12'b0, 8'(ch - CH_0)};
					acc = (v > 20'd65535) ? 16'hFFFF : v[15:0];
					seen = 1'b1;
					pend = 1'b0;
				end else if (!seen && is_space(ch)) begin
					pend = 1'b0;
				end else begin
					if (seen) begin
						c = add_rec(c, K_DUP, CH_NUL);
						c.fd_left = lfd;
						c.fd_right = acc;
					end else begin
						c = add_rec(c, K_ERR, ERR_NO_FD);
					end
					m = M_START;
				end
			end
			M_LBR: begin
				if (is_space(ch)) begin
					c = add_rec(c, K_CHAR, CH_T);
					c = add_rec(c, K_CHAR, CH_E);
					c = add_rec(c, K_CHAR, CH_S);
					c = add_rec(c, K_CHAR, CH_T);
					c = add_rec(c, K_WEND, CH_NUL);
					m = M_START;
					pend = 1'b0;
				end else begin
					c = add_rec(c, K_CHAR, CH_LBR);
					m = M_WORD;
					q = Q_NONE;
				end
			end
			M_BSL: begin
				if (ch == CH_BSL) begin
					m = M_ESC;
					pend = 1'b0;
				end else begin
					c = add_rec(c, K_CHAR, CH_BSL);
					m = M_WORD;
				end
			end
			M_ESC: begin
				m = M_WORD;
				if (ch != CH_NUL) begin
					pend = 1'b0;
					if (ch != CH_NL)
						c = add_rec(c, K_CHAR, ch);
				end
			end
			M_DONE: pend = 1'b0;
			default: ;
		endcase

		// Word step
		if (pend && m == M_WORD) begin
			w = word_step(ch, q, keep_q);
			if (w.emit)
				c = add_rec(c, w.kind, w.data);
			m = w.m;
			q = w.q;
			pend = w.again;
		end

		// Token start step
		if (pend && m == M_START) begin
			pend = 1'b0;
			if (ch == CH_NUL || ch == CH_BAR || ch == CH_AMP) begin
				c = add_rec(c, K_END, CH_NUL);
				m = M_DONE;
			end else if (is_space(ch)) begin
			end else if (ch == CH_GT) begin
				lfd = 4'd1;
				m = M_GT;
			end else if (is_digit(ch)) begin
				held = ch;
				m = M_DIGIT;
			end else if (ch == CH_LT) begin
				c = add_rec(c, K_IN, CH_NUL);
			end else if (ch == CH_LBR && test_conv_q) begin
				held = ch;
				m = M_LBR;
			end else if (ch == CH_RBR && test_conv_q) begin
			end else begin
				m = M_WORD;
				q = Q_NONE;
				pend = 1'b1;
			end
		end

		// Word step after a fresh token start
		if (pend && m == M_WORD) begin
			w = word_step(ch, q, keep_q);
			if (w.emit)
				c = add_rec(c, w.kind, w.data);
			m = w.m;
			q = w.q;
		end

		cmd = c;
		push = accept && (c.nrec != '0);
	end

	// Lexer state, advanced on each accepted transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_START;
			quote_q <= Q_NONE;
			held_q <= '0;
			lfd_q <= 4'd1;
			acc_q <= '0;
			seen_q <= 1'b0;
		end else if (accept) begin
			mode_q <= m;
			quote_q <= q;
			held_q <= held;
			lfd_q <= lfd;
			acc_q <= acc;
			seen_q <= seen;
		end
	end

endmodule

[rtl/core/slt_queue.sv]
// Command queue between lexer front end and record emitter.
// Small register FIFO with head-of-queue read.
// Depends on slt_pkg.
module slt_queue #(
	parameter int DEPTH = slt_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	input  slt_pkg::cmd_t                push_cmd,
	input  logic                         pop,
	output logic                         full,
	output logic                         head_valid,
	output slt_pkg::cmd_t                head_cmd,
	output logic [$clog2(DEPTH+1)-1:0]   count
);
	import slt_pkg::*;

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	cmd_t          mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full       = (count_q == CW'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head_cmd   = mem_q[rd_ptr_q];
	assign count      = count_q;

	// Storage
	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_cmd;
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			if (push && !pop)
				count_q <= count_q + CW'(1);
			else if (pop && !push)
				count_q <= count_q - CW'(1);
		end
	end

endmodule

[rtl/core/slt_back.sv]
// Record emitter: walks the records of the head queue command, one per
// cycle while m_tready allows, into the output register of the master stream.
// Depends on slt_pkg.
module slt_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          head_valid,
	input  slt_pkg::cmd_t head_cmd,
	output logic          pop,
	output logic          m_tvalid,
	input  logic          m_tready,
	output logic [31:0]   m_tdata,   // word_char[7:0], fd_left[11:8], fd_right[27:12], error_code[29:28]
	output logic [2:0]    m_tuser,   // kind
	output logic          m_tlast
);
	import slt_pkg::*;

	logic [NREC_W-1:0] idx_q;
	logic              m_tvalid_q;
	kind_t             kind_q;
	logic [7:0]        wchar_q;
	logic [3:0]        fdl_q;
	logic [15:0]       fdr_q;
	logic [1:0]        ecode_q;
	logic              last_q;

	logic              load;
	logic              is_last;
	rec_t              rec;

	assign load    = head_valid && (!m_tvalid_q || m_tready);
	assign rec     = head_cmd.recs[idx_q];
	assign is_last = (idx_q == head_cmd.nrec - NREC_W'(1));
	assign pop     = load && is_last;

	// Record index within the head command
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (load)
				idx_q <= is_last ? '0 : idx_q + NREC_W'(1);
			if (load)
				m_tvalid_q <= 1'b1;
			else if (m_tready)
				m_tvalid_q <= 1'b0;
		end
	end

	// Output payload, fields zeroed where the kind does not use them
	always_ff @(posedge clk) begin
		if (load) begin
			kind_q <= rec.kind;
			wchar_q <= (rec.kind == K_CHAR) ? rec.data : 8'd0;
			fdl_q <= (rec.kind == K_OUT || rec.kind == K_APP || rec.kind == K_DUP)
				? head_cmd.fd_left : 4'd0;
			fdr_q <= (rec.kind == K_DUP) ? head_cmd.fd_right : 16'd0;
			ecode_q <= (rec.kind == K_ERR) ? rec.data[1:0] : 2'd0;
			last_q <= is_last;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = kind_q;
	assign m_tdata  = {2'b00, ecode_q, fdr_q, fdl_q, wchar_q};
	assign m_tlast  = last_q;

endmodule

[rtl/core/shell_line_tokenizer.sv]
// Shell command-line tokenizer, top level.
// Instantiates slt_front, slt_queue and slt_back; depends on slt_pkg.
//
// One command-line byte per transaction enters on s_tdata (start_line on
// s_tuser) and is lexed in the cycle it is accepted; a new byte can be
// taken every cycle as long as the command queue (QUEUE_DEPTH entries)
// has room. Each byte yields zero to five records. The emitter sends one
// record per cycle from the head of the queue while m_tready is not held
// low; the sustained rate is one byte per cycle when bytes average one
// record or fewer. Bytes that cause no record never enter the queue. An
// accepted byte's records are written to a queue entry and then to the
// output register.
module shell_line_tokenizer #(
	parameter int QUEUE_DEPTH = slt_pkg::QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic        cfg_wdata,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // ch[7:0]
	input  logic        s_tuser,   // start_line
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // word_char[7:0], fd_left[11:8], fd_right[27:12], error_code[29:28]
	output logic [2:0]  m_tuser,   // kind
	output logic        m_tlast    // last record of this byte
);
	import slt_pkg::*;

	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	logic          accept;
	logic          push;
	cmd_t          push_cmd;
	logic          full;
	logic          head_valid;
	cmd_t          head_cmd;
	logic          pop;
	logic [CW-1:0] q_count;

	assign s_tready = !full;
	assign accept   = s_tvalid && s_tready;

	slt_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.accept    (accept),
		.ch        (s_tdata),
		.start_line(s_tuser),
		.push      (push),
		.cmd       (push_cmd)
	);

	slt_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_cmd  (push_cmd),
		.pop       (pop),
		.full      (full),
		.head_valid(head_valid),
		.head_cmd  (head_cmd),
		.count     (q_count)
	);

	slt_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head_valid(head_valid),
		.head_cmd  (head_cmd),
		.pop       (pop),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

	// Queue never overfills
	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		q_count <= CW'(QUEUE_DEPTH))
		else $error("command queue overfilled");

	// A queued command always holds one to five records
	a_cmd_size: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (push_cmd.nrec != '0) && (push_cmd.nrec <= NREC_W'(MAX_RECS)))
		else $error("bad record count in command");

	// Error records carry a nonzero code, character records nothing else
	a_err_code: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser == K_ERR) |-> (m_tdata[29:28] != 2'd0))
		else $error("error record without a code");

	a_char_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser == K_CHAR) |-> (m_tdata[31:8] == 24'd0))
		else $error("character record with stray fields");

endmodule
